// File: hdl/key_index_sort_with_change_check_assert.svh
// ----------------------------------------------------------------------------
// key index sorter assertion macros
// shared helpers for concurrent checks, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef KEY_INDEX_SORT_WITH_CHANGE_CHECK_ASSERT_SVH
`define KEY_INDEX_SORT_WITH_CHANGE_CHECK_ASSERT_SVH

// same-cycle implication
`define KSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ksc_pkg.sv
// ----------------------------------------------------------------------------
// key index sorter package
// sizes, request types, chain slot type and state codes
// ----------------------------------------------------------------------------
`default_nettype none

package ksc_pkg;

    localparam int ENTRIES   = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int KEY_W     = 64;
    localparam int OLD_POS_W = 64;
    localparam int POS_W     = 6;

    typedef struct packed {
        logic [KEY_W-1:0]     key_hash;
        logic [KEY_W-1:0]     old_key;
        logic [OLD_POS_W-1:0] old_position;
        logic                 final_item;
    } t_in_req;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_key;
        logic [POS_W-1:0] sorted_position;
        logic             end_of_list;
        logic             differs;
        logic             overflowed;
    } t_out_req;

    // one sorted entry held in a cell
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] tag;
    } t_slot;

    typedef struct packed {
        logic load;
        logic drain;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        S_LOAD,
        S_PREP,
        S_DRAIN
    } t_state;

endpackage

`default_nettype wire

// File: hdl/ksc_cell.sv
// ----------------------------------------------------------------------------
// key index sorter cell
// one slot of the insertion chain: hold, shift right on insert, shift left on drain
// ----------------------------------------------------------------------------
`default_nettype none

module ksc_cell import ksc_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_chain_ctl i_ctl,
    input  t_slot      i_new,
    input  t_slot      i_prev,
    input  wire        i_prev_keep,
    input  t_slot      i_next,
    output t_slot      o_slot,
    output logic       o_keep
);

    t_slot r_slot;
    t_slot n_slot;

    // equal keys stay ahead: a newer entry always has the larger tag
    assign o_keep = r_slot.valid && !(i_new.key < r_slot.key);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.drain) begin
            n_slot = i_next;
        end else if (i_ctl.load && !o_keep) begin
            n_slot = i_prev_keep ? i_new : i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ksc_chain.sv
// ----------------------------------------------------------------------------
// key index sorter chain
// row of cells kept in ascending order, head cell at position zero
// ----------------------------------------------------------------------------
`default_nettype none

module ksc_chain import ksc_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_chain_ctl i_ctl,
    input  t_slot      i_new,
    output t_slot      o_head
);

    t_slot w_slot [ENTRIES];
    t_slot w_prev [ENTRIES];
    t_slot w_next [ENTRIES];
    logic  w_keep      [ENTRIES];
    logic  w_prev_keep [ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_prev[g]      = '0;
            assign w_prev_keep[g] = 1'b1;
        end else begin : g_mid
            assign w_prev[g]      = w_slot[g-1];
            assign w_prev_keep[g] = w_keep[g-1];
        end
        if (g == ENTRIES - 1) begin : g_last
            assign w_next[g] = '0;
        end else begin : g_inner
            assign w_next[g] = w_slot[g+1];
        end

        ksc_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_new       (i_new),
            .i_prev      (w_prev[g]),
            .i_prev_keep (w_prev_keep[g]),
            .i_next      (w_next[g]),
            .o_slot      (w_slot[g]),
            .o_keep      (w_keep[g])
        );
    end

    assign o_head = w_slot[0];

endmodule

`default_nettype wire

// File: hdl/key_index_sort_with_change_check.sv
// ----------------------------------------------------------------------------
// key index sort with change check
// insertion-chain argsort of 64-bit keys with a compare against old records
// ----------------------------------------------------------------------------
// loading takes one request per cycle: each key is inserted into a chain of
// ENTRIES cells in the same cycle it arrives, while its old record is written
// to a record memory in arrival order. the request flagged final_item closes
// the list; input then stalls through the record memory prefetch state and
// the drain state, while the chain shifts out toward its head (held when
// the output side stalls). each drained entry is checked against the old
// record read from memory at the same sorted index; the mismatch summary and
// the overflow flag ride on the last entry. requests arriving with the chain
// full are dropped and raise the overflow flag; a dropped final request still
// closes the list. the output register lets loading of the next list start
// while the last result is still waiting to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_index_sort_with_change_check_assert.svh"

module key_index_sort_with_change_check import ksc_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_valid,
    output logic     o_stall,
    input  t_in_req  i_data,
    output logic     o_valid,
    input  wire      i_stall,
    output t_out_req o_data
);

    // control state
    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] n_left;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [IDX_W-1:0] n_rd_ptr;
    logic             r_ovf;
    logic             n_ovf;
    logic             r_diff;
    logic             n_diff;
    logic             r_out_valid;

    // payload
    t_out_req         r_out;
    t_out_req         n_out;
    logic [KEY_W+OLD_POS_W-1:0] r_old_q;

    // old record memory, arrival order
    logic [KEY_W+OLD_POS_W-1:0] r_old_mem [ENTRIES];

    // handshake and chain control
    logic       w_accept;
    logic       w_room;
    logic       w_ins;
    logic       w_move;
    logic       w_last;
    logic       w_mismatch;
    t_chain_ctl w_ctl;
    t_slot      w_new;
    t_slot      w_head;
    logic [OLD_POS_W-1:0] w_head_pos;
    logic [KEY_W-1:0]     w_old_key;
    logic [OLD_POS_W-1:0] w_old_pos;

    // input side
    assign w_accept = i_valid && !o_stall;
    assign w_room   = (r_fill != CNT_W'(ENTRIES));
    assign w_ins    = w_accept && w_room;

    // drain side: one entry leaves the chain when the output register is free
    assign w_move = (r_state == S_DRAIN) && (!r_out_valid || !i_stall);
    assign w_last = (r_left == CNT_W'(1));

    assign w_new.valid = 1'b1;
    assign w_new.key   = i_data.key_hash;
    assign w_new.tag   = r_fill[IDX_W-1:0];

    assign w_ctl.load  = w_ins;
    assign w_ctl.drain = w_move;

    ksc_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_new   (w_new),
        .o_head  (w_head)
    );

    // compare the head against the old record at the same sorted index
    assign w_head_pos = OLD_POS_W'(w_head.tag);
    assign w_old_key  = r_old_q[KEY_W+OLD_POS_W-1:OLD_POS_W];
    assign w_old_pos  = r_old_q[OLD_POS_W-1:0];
    assign w_mismatch = (w_head.key != w_old_key) || (w_head_pos != w_old_pos);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_data.final_item) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_move && w_last) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state outputs: input stalls outside loading
    always_comb begin
        case (r_state)
            S_LOAD:  o_stall = 1'b0;
            S_PREP:  o_stall = 1'b1;
            S_DRAIN: o_stall = 1'b1;
            default: o_stall = 1'b1;
        endcase
    end

    // counters and flags
    always_comb begin
        n_fill   = r_fill;
        n_left   = r_left;
        n_rd_ptr = r_rd_ptr;
        n_ovf    = r_ovf;
        n_diff   = r_diff;
        if (w_ins) begin
            n_fill = r_fill + CNT_W'(1);
        end
        if (w_accept && !w_room) begin
            n_ovf = 1'b1;
        end
        if (w_accept && i_data.final_item) begin
            // list closes: remember its length, restart the fill count
            n_left = w_room ? (r_fill + CNT_W'(1)) : r_fill;
            n_fill = '0;
            n_diff = 1'b0;
        end
        if (w_move) begin
            n_left   = r_left - CNT_W'(1);
            n_rd_ptr = r_rd_ptr + IDX_W'(1);
            n_diff   = r_diff || w_mismatch;
            if (w_last) begin
                n_rd_ptr = '0;
                n_ovf    = 1'b0;
                n_diff   = 1'b0;
            end
        end
    end

    // result built from the chain head
    always_comb begin
        n_out.sorted_key      = w_head.key;
        n_out.sorted_position = w_head_pos[POS_W-1:0];
        n_out.end_of_list     = w_last;
        n_out.differs         = w_last && (r_diff || w_mismatch);
        n_out.overflowed      = w_last && r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_left      <= '0;
            r_rd_ptr    <= '0;
            r_ovf       <= 1'b0;
            r_diff      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_left   <= n_left;
            r_rd_ptr <= n_rd_ptr;
            r_ovf    <= n_ovf;
            r_diff   <= n_diff;
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register, loads only when a result moves in
    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= n_out;
        end
    end

    // old record memory: write on insert, registered read at next pointer
    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_old_mem[r_fill[IDX_W-1:0]] <= {i_data.old_key, i_data.old_position};
        end
        r_old_q <= r_old_mem[n_rd_ptr];
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    `KSC_ASSERT_NOW(a_drain_head_valid, r_state == S_DRAIN, w_head.valid,
        "chain head empty while entries remain to drain")
    `KSC_ASSERT_NOW(a_drain_left_nonzero, r_state == S_DRAIN, r_left != '0,
        "drain running with no entries left")
    `KSC_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= CNT_W'(ENTRIES),
        "fill count beyond capacity")
    `KSC_ASSERT_NEXT(a_drain_done, w_move && w_last,
        r_state == S_LOAD && !w_head.valid && o_valid && o_data.end_of_list,
        "last entry left but chain not empty or list not closed")

endmodule

`default_nettype wire

// File: tb/sv/key_index_sort_with_change_check_tb.sv
// ----------------------------------------------------------------------------
// key index sort with change check testbench
// drives lists of keys with old index records and checks every sorted entry,
// the change flag and the overflow flag against a behavioral predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_index_sort_with_change_check_tb import ksc_pkg::*;;

    // key sources for generated lists
    localparam int KM_RANDOM = 0;
    localparam int KM_FEW    = 1;
    localparam int KM_EDGE   = 2;
    localparam int KM_SAME   = 3;
    localparam int KM_CHOSEN = 4;

    // old record sources for generated lists
    localparam int OM_RANDOM = 0;
    localparam int OM_MATCH  = 1;
    localparam int OM_FLIP   = 2;

    localparam int HOLD_CYCLES = 300;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    t_in_req  i_data  = '0;
    logic     i_stall = 1'b0;
    logic     o_stall;
    logic     o_valid;
    t_out_req o_data;

    key_index_sort_with_change_check u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // requests waiting for the driver, sorted entries waiting for the block
    t_in_req  pending_requests[$];
    t_out_req expected_entries[$];

    int mismatch_count = 0;
    int accepted_total = 0;
    int queued_total   = 0;
    int hold_start     = -1;

    // scratch area shared by the argsort and the list builder
    logic [KEY_W-1:0] rank_key  [ENTRIES];
    int               rank_slot [ENTRIES];
    logic [KEY_W-1:0] chosen_key[ENTRIES];
    logic [KEY_W-1:0] same_key;

    // predictor copy of the list being loaded
    logic [KEY_W-1:0]     held_key     [ENTRIES];
    logic [KEY_W-1:0]     held_old_key [ENTRIES];
    logic [OLD_POS_W-1:0] held_old_pos [ENTRIES];
    int                   held_count    = 0;
    bit                   held_overflow = 1'b0;

    // strict order: key first, then arrival slot
    function automatic bit slot_precedes(input int a, input int b);
        if (rank_key[a] != rank_key[b])
            return rank_key[a] < rank_key[b];
        return a < b;
    endfunction

    // insertion argsort of rank_key[0..count-1] into rank_slot
    function automatic void order_keys(input int count);
        int i;
        int j;
        int cur;
        for (i = 0; i < count; i++)
            rank_slot[i] = i;
        for (i = 1; i < count; i++) begin
            cur = rank_slot[i];
            j = i;
            while (j > 0 && slot_precedes(cur, rank_slot[j-1])) begin
                rank_slot[j] = rank_slot[j-1];
                j--;
            end
            rank_slot[j] = cur;
        end
    endfunction

    // fold one accepted request into the predicted list, emit on final
    task automatic absorb_request(input t_in_req r);
        t_out_req e;
        bit       changed;
        int       i;
        int       s;
        if (held_count < ENTRIES) begin
            held_key[held_count]     = r.key_hash;
            held_old_key[held_count] = r.old_key;
            held_old_pos[held_count] = r.old_position;
            held_count++;
        end else begin
            // full store: drop the request, remember it
            held_overflow = 1'b1;
        end
        if (r.final_item) begin
            for (i = 0; i < held_count; i++)
                rank_key[i] = held_key[i];
            order_keys(held_count);
            changed = 1'b0;
            // sorted entry i against the old record that came in at slot i
            for (i = 0; i < held_count; i++) begin
                s = rank_slot[i];
                if (held_key[s] != held_old_key[i] || 64'(s) != held_old_pos[i])
                    changed = 1'b1;
            end
            for (i = 0; i < held_count; i++) begin
                s = rank_slot[i];
                e.sorted_key      = held_key[s];
                e.sorted_position = POS_W'(s);
                e.end_of_list     = (i == held_count - 1);
                e.differs         = (i == held_count - 1) && changed;
                e.overflowed      = (i == held_count - 1) && held_overflow;
                expected_entries.push_back(e);
            end
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of requests with random gaps, payload held while stalled
    // ------------------------------------------------------------------------
    int burst_left = 4;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data  <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                absorb_request(i_data);
                accepted_total++;
            end
            // only move on once the current request is gone
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    i_data  <= pending_requests.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks each taken entry, stalls on a pattern of its own
    // ------------------------------------------------------------------------
    int rx_mode   = 0;
    int rx_left   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    task automatic check_entry(input t_out_req got);
        t_out_req want;
        if (expected_entries.size() == 0) begin
            $error("unexpected entry: sorted_key %h sorted_position %0d",
                   got.sorted_key, got.sorted_position);
            mismatch_count++;
        end else begin
            want = expected_entries.pop_front();
            if (got.sorted_key !== want.sorted_key) begin
                $error("sorted_key: expected %h, actual %h", want.sorted_key, got.sorted_key);
                mismatch_count++;
            end
            if (got.sorted_position !== want.sorted_position) begin
                $error("sorted_position: expected %0d, actual %0d",
                       want.sorted_position, got.sorted_position);
                mismatch_count++;
            end
            if (got.end_of_list !== want.end_of_list) begin
                $error("end_of_list: expected %b, actual %b", want.end_of_list, got.end_of_list);
                mismatch_count++;
            end
            if (got.differs !== want.differs) begin
                $error("differs: expected %b, actual %b", want.differs, got.differs);
                mismatch_count++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %b, actual %b", want.overflowed, got.overflowed);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                check_entry(o_data);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && hold_start >= 0 && accepted_total >= hold_start) begin
                // long hold-off so the chain fills and input backs up
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall  <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_left = $urandom_range(8, 60);
                end else begin
                    rx_left--;
                end
                case (rx_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // list builder
    // ------------------------------------------------------------------------
    function automatic logic [KEY_W-1:0] pick_key(input int mode, input int idx);
        case (mode)
            KM_FEW:    return KEY_W'($urandom_range(0, 3));
            KM_EDGE: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return '1;
                    2: return KEY_W'(1);
                    3: return {{(KEY_W-1){1'b1}}, 1'b0};
                    default: return {$urandom, $urandom};
                endcase
            end
            KM_SAME:   return same_key;
            KM_CHOSEN: return chosen_key[idx];
            default:   return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_request(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] okey,
                                input logic [OLD_POS_W-1:0] opos, input logic last);
        t_in_req r;
        r.key_hash     = key;
        r.old_key      = okey;
        r.old_position = opos;
        r.final_item   = last;
        pending_requests.push_back(r);
        queued_total++;
    endtask

    // one list: stored requests, then dropped ones, final on the very last
    task automatic queue_list(input int stored, input int dropped,
                              input int key_mode, input int old_mode);
        t_in_req r;
        int      total;
        int      i;
        int      flip_at;
        int      flip_bit;
        total = stored + dropped;
        for (i = 0; i < stored; i++)
            rank_key[i] = pick_key(key_mode, i);
        order_keys(stored);
        flip_at = (old_mode == OM_FLIP) ? $urandom_range(0, stored - 1) : -1;
        for (i = 0; i < total; i++) begin
            r.key_hash = (i < stored) ? rank_key[i] : pick_key(KM_RANDOM, i);
            if (old_mode == OM_RANDOM || i >= stored) begin
                r.old_key      = {$urandom, $urandom};
                r.old_position = {$urandom, $urandom};
            end else begin
                // the old record already holds the sorted result
                r.old_key      = rank_key[rank_slot[i]];
                r.old_position = OLD_POS_W'(rank_slot[i]);
            end
            if (i == flip_at) begin
                flip_bit = $urandom_range(0, 63);
                if ($urandom_range(0, 1))
                    r.old_key[flip_bit] = ~r.old_key[flip_bit];
                else
                    r.old_position[flip_bit] = ~r.old_position[flip_bit];
            end
            r.final_item = (i == total - 1);
            pending_requests.push_back(r);
            queued_total++;
        end
    endtask

    // everything handed over and every sorted entry taken
    task automatic wait_all_done();
        while (pending_requests.size() != 0 || i_valid || expected_entries.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int km;
        int om;
        int small_items;
        int roll;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single entry, old record matches
        push_request('0, '0, '0, 1'b1);
        // single entry, old position only differs in its top bit
        push_request('1, '1, {1'b1, {(OLD_POS_W-1){1'b0}}}, 1'b1);
        // ties on both extremes, old records already sorted
        chosen_key[0] = '1;
        chosen_key[1] = '0;
        chosen_key[2] = '1;
        chosen_key[3] = '0;
        queue_list(4, 0, KM_CHOSEN, OM_MATCH);
        // strictly descending keys, random old records
        chosen_key[0] = 64'hffff_ffff_0000_0000;
        chosen_key[1] = 64'h8000_0000_0000_0000;
        chosen_key[2] = 64'h0123_4567_89ab_cdef;
        chosen_key[3] = 64'h0000_0000_0000_0001;
        chosen_key[4] = '0;
        queue_list(5, 0, KM_CHOSEN, OM_RANDOM);
        // all keys equal
        same_key = {$urandom, $urandom};
        queue_list(3, 0, KM_SAME, OM_MATCH);
        // one bit off in a single old record
        queue_list(4, 0, KM_EDGE, OM_FLIP);

        // sender pauses until the block has given back every entry
        wait_all_done();

        // full list with a dropped request and a dropped final one,
        // receiver holds off a while into it
        hold_start = queued_total + 8;
        queue_list(ENTRIES, 2, KM_FEW, OM_MATCH);

        small_items = 0;
        while (small_items < 46) begin
            n  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            km = $urandom_range(KM_RANDOM, KM_SAME);
            same_key = {$urandom, $urandom};
            roll = $urandom_range(0, 9);
            om = (roll < 4) ? OM_MATCH : (roll < 7) ? OM_FLIP : OM_RANDOM;
            queue_list(n, 0, km, om);
            small_items += n;
        end

        wait_all_done();
        repeat (100) @(posedge i_clk);

        if (expected_entries.size() != 0) begin
            $error("%0d sorted entries never arrived", expected_entries.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial begin
        #4_800_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
